// ===== hdl/elfn_pkg.sv =====
// ---------------------------------------------------------------------------
// elfn_pkg
// shared types and constants of the note record deframer
// ---------------------------------------------------------------------------
`default_nettype none

package elfn_pkg;

	localparam int unsigned HDR_BYTES     = 12;
	localparam int unsigned DEFAULT_ALIGN = 4;

	localparam logic [1:0] CFG_SECTION_SIZE = 2'd0;
	localparam logic [1:0] CFG_ALIGNMENT    = 2'd1;
	localparam logic [1:0] CFG_BIG_ENDIAN   = 2'd2;

	localparam logic [1:0] CLS_HEADER = 2'd0;
	localparam logic [1:0] CLS_NAME   = 2'd1;
	localparam logic [1:0] CLS_DESC   = 2'd2;
	localparam logic [1:0] CLS_PAD    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNCATED = 2'd1;
	localparam logic [1:0] ST_BEYOND    = 2'd2;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_NAME    = 5'b00010,
		PH_NAMEPAD = 5'b00100,
		PH_DESC    = 5'b01000,
		PH_DESCPAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [31:0] section_size;
		logic [6:0]  field_alignment;
		logic        big_endian;
	} cfg_t;

	typedef struct packed {
		logic [31:0] descriptor_length;
		logic [31:0] name_length;
		logic [31:0] note_type;
		logic [7:0]  out_byte;
		logic [1:0]  status;
		logic        section_end;
		logic        record_end;
		logic [1:0]  byte_class;
	} res_t;

	function automatic logic [6:0] pad_for(input logic [31:0] size, input logic [6:0] mask);
		return (7'd0 - size[6:0]) & mask;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/elfn_parse.sv =====
// ---------------------------------------------------------------------------
// elfn_parse
// record parse state and the per-byte classification logic
// ---------------------------------------------------------------------------
`default_nettype none

module elfn_parse
	import elfn_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [7:0] byte_in,
	input  wire logic       start_in,
	input  wire cfg_t       cfg,
	output res_t            res
);

	phase_t      phase_q, phase_d;
	logic [31:0] hs_q [3];
	logic [31:0] hs_d [3];
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] frem_q, frem_d;
	logic [6:0]  prem_q, prem_d;
	logic [31:0] pos_q, pos_d;

	always_comb begin
		phase_t      ph;
		logic [31:0] hs [3];
		logic [3:0]  cnt;
		logic [31:0] frem;
		logic [6:0]  prem;
		logic [31:0] pos;
		logic [6:0]  align;
		logic [6:0]  mask;
		logic [6:0]  p;
		logic [1:0]  w;
		logic [31:0] shifted;
		logic        beyond;
		logic        sec_end;
		logic        rec_end;
		logic        show;
		logic [1:0]  cls;

		ph   = start_in ? PH_HEADER : phase_q;
		for (int i = 0; i < 3; i++)
			hs[i] = start_in ? 32'd0 : hs_q[i];
		cnt  = start_in ? 4'd0 : hdr_cnt_q;
		frem = start_in ? 32'd0 : frem_q;
		prem = start_in ? 7'd0 : prem_q;
		pos  = start_in ? 32'd0 : pos_q;

		align   = (cfg.field_alignment == 7'd0) ? 7'(DEFAULT_ALIGN) : cfg.field_alignment;
		mask    = align - 7'd1;
		beyond  = pos >= cfg.section_size;
		sec_end = ({1'b0, pos} + 33'd1) == {1'b0, cfg.section_size};
		w       = (cnt[3:2] == 2'd3) ? 2'd0 : cnt[3:2];
		shifted = cfg.big_endian ? {hs[w][23:0], byte_in} : {byte_in, hs[w][31:8]};

		phase_d   = ph;
		hs_d      = hs;
		hdr_cnt_d = cnt;
		frem_d    = frem;
		prem_d    = prem;
		pos_d     = pos;
		rec_end   = 1'b0;
		show      = 1'b1;
		cls       = CLS_HEADER;
		p         = 7'd0;

		if (!beyond) begin
			pos_d = pos + 32'd1;
			unique case (ph)
				PH_NAME: begin
					cls    = CLS_NAME;
					frem_d = frem - 32'd1;
					if (frem_d == 32'd0) begin
						p = pad_for(hs[0], mask);
						if (p != 7'd0) begin
							phase_d = PH_NAMEPAD;
							prem_d  = p;
						end else if (hs[1] != 32'd0) begin
							phase_d = PH_DESC;
							frem_d  = hs[1];
						end else begin
							phase_d   = PH_HEADER;
							hdr_cnt_d = 4'd0;
							rec_end   = 1'b1;
						end
					end
				end
				PH_NAMEPAD: begin
					cls    = CLS_PAD;
					prem_d = prem - 7'd1;
					if (prem_d == 7'd0) begin
						if (hs[1] != 32'd0) begin
							phase_d = PH_DESC;
							frem_d  = hs[1];
						end else begin
							phase_d   = PH_HEADER;
							hdr_cnt_d = 4'd0;
							rec_end   = 1'b1;
						end
					end
				end
				PH_DESC: begin
					cls    = CLS_DESC;
					frem_d = frem - 32'd1;
					if (frem_d == 32'd0) begin
						p = pad_for(hs[1], mask);
						if (p != 7'd0) begin
							phase_d = PH_DESCPAD;
							prem_d  = p;
						end else begin
							phase_d   = PH_HEADER;
							hdr_cnt_d = 4'd0;
							rec_end   = 1'b1;
						end
					end
				end
				PH_DESCPAD: begin
					cls    = CLS_PAD;
					prem_d = prem - 7'd1;
					if (prem_d == 7'd0) begin
						phase_d   = PH_HEADER;
						hdr_cnt_d = 4'd0;
						rec_end   = 1'b1;
					end
				end
				default: begin
					cls       = CLS_HEADER;
					phase_d   = PH_HEADER;
					hs_d[w]   = shifted;
					hdr_cnt_d = cnt + 4'd1;
					show      = 1'b0;
					if (hdr_cnt_d >= 4'(HDR_BYTES)) begin
						hdr_cnt_d = 4'd0;
						show      = 1'b1;
						if (hs_d[0] != 32'd0) begin
							phase_d = PH_NAME;
							frem_d  = hs_d[0];
						end else if (hs_d[1] != 32'd0) begin
							phase_d = PH_DESC;
							frem_d  = hs_d[1];
						end else begin
							rec_end = 1'b1;
						end
					end
				end
			endcase
		end

		res.out_byte = byte_in;
		if (beyond) begin
			res.byte_class        = CLS_PAD;
			res.note_type         = 32'd0;
			res.name_length       = 32'd0;
			res.descriptor_length = 32'd0;
			res.record_end        = 1'b0;
			res.section_end       = 1'b0;
			res.status            = ST_BEYOND;
		end else begin
			res.byte_class        = cls;
			res.note_type         = show ? hs_d[2] : 32'd0;
			res.name_length       = show ? hs_d[0] : 32'd0;
			res.descriptor_length = show ? hs_d[1] : 32'd0;
			res.record_end        = rec_end;
			res.section_end       = sec_end;
			res.status            = (sec_end && !rec_end) ? ST_TRUNCATED : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hs_q[0]   <= 32'd0;
			hs_q[1]   <= 32'd0;
			hs_q[2]   <= 32'd0;
			hdr_cnt_q <= 4'd0;
			frem_q    <= 32'd0;
			prem_q    <= 7'd0;
			pos_q     <= 32'd0;
		end else if (adv) begin
			phase_q   <= phase_d;
			hs_q      <= hs_d;
			hdr_cnt_q <= hdr_cnt_d;
			frem_q    <= frem_d;
			prem_q    <= prem_d;
			pos_q     <= pos_d;
		end
	end

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= 4'd11)
		else $error("header byte count out of range");

	a_field_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NAME || phase_q == PH_DESC) |-> frem_q != 32'd0)
		else $error("field phase with nothing left to pass");

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NAMEPAD || phase_q == PH_DESCPAD) |-> prem_q != 7'd0)
		else $error("padding phase with nothing left to skip");

	a_rec_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.record_end |=> phase_q == PH_HEADER && hdr_cnt_q == 4'd0)
		else $error("record end did not return to header phase");

endmodule

`default_nettype wire

// ===== hdl/elf_note_record_deframer_unit.sv =====
// a taken byte is held in the input stage, and its result is then registered in the result register
// throughput: one byte per cycle while the output is not stalled; the parse state updates once per byte
// an input stage and a result register decouple the two stream sides
// reset clears the configuration, the parse state and both valid flags
// ---------------------------------------------------------------------------
// elf_note_record_deframer_unit
// tags each byte of a note section with its record role
// ---------------------------------------------------------------------------
`default_nettype none

module elf_note_record_deframer_unit
	import elfn_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte
	input  wire logic [0:0]   s_tuser,   // section_start
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // out_byte, note_type, name_length, descriptor_length
	output logic [4:0]        m_tuser,   // byte_class, section_end, status
	output logic              m_tlast,   // record_end
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       m_valid_q;
	res_t       res_q;
	res_t       res;
	logic       adv;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SECTION_SIZE: cfg_q.section_size    <= cfg_data;
				CFG_ALIGNMENT:    cfg_q.field_alignment <= cfg_data[6:0];
				CFG_BIG_ENDIAN:   cfg_q.big_endian      <= cfg_data[0];
				default:          cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	elfn_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_in (byte_s1),
		.start_in(start_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {res_q.descriptor_length, res_q.name_length, res_q.note_type,
		res_q.out_byte};
	assign m_tuser  = {res_q.status, res_q.section_end, res_q.byte_class};
	assign m_tlast  = res_q.record_end;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the note record deframer: builds note sections
// from well-formed records with random sizes, alignment and byte order,
// mixes in cut-short sections, stray section starts and bytes past the end,
// and compares every tagged output transfer with a cycle-free predictor
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
	import elfn_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	class note_tagger;
		logic [31:0] sec_size;
		logic [6:0]  align;
		logic        big_end;
		phase_t      ph;
		logic [31:0] hdr [3];
		logic [3:0]  hdr_cnt;
		logic [31:0] fld_left;
		logic [6:0]  pad_left;
		logic [31:0] sec_pos;
		res_t        expected_tags [$];
		int unsigned mismatches;

		function new();
			sec_size = '0;
			align = '0;
			big_end = 1'b0;
			mismatches = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			ph = PH_HEADER;
			hdr = '{default: '0};
			hdr_cnt = '0;
			fld_left = '0;
			pad_left = '0;
			sec_pos = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_SECTION_SIZE: sec_size = val;
				CFG_ALIGNMENT:    align = val[6:0];
				CFG_BIG_ENDIAN:   big_end = val[0];
				default: ;
			endcase
		endfunction

		function logic [6:0] pad_len(logic [31:0] size);
			logic [6:0] mask;
			mask = (align == 7'd0) ? 7'(DEFAULT_ALIGN - 1) : align - 7'd1;
			return (7'd0 - size[6:0]) & mask;
		endfunction

		// leave the name part: go to the descriptor or close the record
		function logic desc_or_done();
			if (hdr[1] != '0) begin
				ph = PH_DESC;
				fld_left = hdr[1];
				return 1'b0;
			end
			ph = PH_HEADER;
			hdr_cnt = '0;
			return 1'b1;
		endfunction

		function void take_byte(logic [7:0] d, logic st);
			res_t       r;
			logic [6:0] p;
			logic [1:0] w;
			logic       rec_end;
			logic       sec_end;
			if (st)
				clear_parse();
			r = '0;
			r.out_byte = d;
			if (sec_pos >= sec_size) begin
				r.byte_class = CLS_PAD;
				r.status = ST_BEYOND;
				expected_tags = {expected_tags, r};
				return;
			end
			sec_end = ({1'b0, sec_pos} + 33'd1) == {1'b0, sec_size};
			sec_pos++;
			rec_end = 1'b0;
			case (ph)
				PH_NAME: begin
					r.byte_class = CLS_NAME;
					fld_left--;
					if (fld_left == '0) begin
						p = pad_len(hdr[0]);
						if (p != '0) begin
							ph = PH_NAMEPAD;
							pad_left = p;
						end else begin
							rec_end = desc_or_done();
						end
					end
				end
				PH_NAMEPAD: begin
					r.byte_class = CLS_PAD;
					pad_left--;
					if (pad_left == '0)
						rec_end = desc_or_done();
				end
				PH_DESC: begin
					r.byte_class = CLS_DESC;
					fld_left--;
					if (fld_left == '0) begin
						p = pad_len(hdr[1]);
						if (p != '0) begin
							ph = PH_DESCPAD;
							pad_left = p;
						end else begin
							ph = PH_HEADER;
							hdr_cnt = '0;
							rec_end = 1'b1;
						end
					end
				end
				PH_DESCPAD: begin
					r.byte_class = CLS_PAD;
					pad_left--;
					if (pad_left == '0) begin
						ph = PH_HEADER;
						hdr_cnt = '0;
						rec_end = 1'b1;
					end
				end
				default: begin
					r.byte_class = CLS_HEADER;
					ph = PH_HEADER;
					w = hdr_cnt[3:2];
					if (big_end)
						hdr[w] = {hdr[w][23:0], d};
					else
						hdr[w] = {d, hdr[w][31:8]};
					hdr_cnt++;
					if (hdr_cnt >= 4'(HDR_BYTES)) begin
						hdr_cnt = '0;
						if (hdr[0] != '0) begin
							ph = PH_NAME;
							fld_left = hdr[0];
						end else begin
							rec_end = desc_or_done();
						end
					end
				end
			endcase
			if (r.byte_class != CLS_HEADER || ph != PH_HEADER || rec_end) begin
				r.note_type = hdr[2];
				r.name_length = hdr[0];
				r.descriptor_length = hdr[1];
			end
			r.record_end = rec_end;
			r.section_end = sec_end;
			r.status = (sec_end && !rec_end) ? ST_TRUNCATED : ST_OK;
			expected_tags = {expected_tags, r};
		endfunction

		function void check_field(string fname, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, actual %0h", fname, want, got);
				mismatches++;
			end
		endfunction

		function void match_tag(logic [103:0] tdata, logic [4:0] tuser, logic tlast);
			res_t e;
			if (expected_tags.size() == 0) begin
				$error("unexpected output transfer, byte %0h", tdata[7:0]);
				mismatches++;
				return;
			end
			e = expected_tags.pop_front();
			check_field("out_byte", 32'(e.out_byte), 32'(tdata[7:0]));
			check_field("note_type", e.note_type, tdata[39:8]);
			check_field("name_length", e.name_length, tdata[71:40]);
			check_field("descriptor_length", e.descriptor_length, tdata[103:72]);
			check_field("byte_class", 32'(e.byte_class), 32'(tuser[1:0]));
			check_field("section_end", 32'(e.section_end), 32'(tuser[2]));
			check_field("status", 32'(e.status), 32'(tuser[4:3]));
			check_field("record_end", 32'(e.record_end), 32'(tlast));
		endfunction

		function int unsigned pending();
			return expected_tags.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [7:0]    s_tdata = '0;
	logic [0:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [103:0]  m_tdata;
	logic [4:0]    m_tuser;
	logic          m_tlast;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_index = '0;
	logic [31:0]   cfg_data = '0;

	note_tagger    tags;
	logic [7:0]    sect [$];
	int unsigned   src_idle_pct = 29;
	int unsigned   snk_idle_pct = 68;
	int unsigned   bytes_sent = 0;

	elf_note_record_deframer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tags.take_byte(s_tdata, s_tuser[0]);
		if (arst_n && m_tvalid && m_tready)
			tags.match_tag(m_tdata, m_tuser, m_tlast);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		tags.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] d, input logic st);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drain();
		do @(posedge clk); while (tags.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_word(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			sect = {sect, (tags.big_end ? v[31 - 8 * i -: 8] : v[8 * i +: 8])};
	endtask

	// header plus body; cap limits the body for records larger than the section
	task automatic add_record(input logic [31:0] nsz, input logic [31:0] dsz,
			input logic [31:0] typ, input int unsigned cap);
		longint unsigned body;
		add_word(nsz);
		add_word(dsz);
		add_word(typ);
		body = 64'(nsz) + 64'(tags.pad_len(nsz)) + 64'(dsz) + 64'(tags.pad_len(dsz));
		if (body > cap)
			body = cap;
		for (longint unsigned i = 0; i < body; i++)
			sect = {sect, 8'($urandom)};
	endtask

	task automatic play(input int extra, input int pause_at, input bit noisy);
		int   total;
		logic st;
		total = sect.size() + extra;
		for (int i = 0; i < total; i++) begin
			if (i == pause_at) begin
				stop_sending();
				wait_drain();
			end
			if (i == 0)
				st = !noisy || ($urandom_range(15) != 0);
			else
				st = noisy && ($urandom_range(199) == 0);
			send_byte((i < sect.size()) ? sect[i] : 8'($urandom), st);
		end
		stop_sending();
		wait_drain();
	endtask

	task automatic random_section();
		int unsigned n_rec;
		int          extra;
		logic [6:0]  al;
		logic [31:0] sz;
		logic [31:0] nsz;
		logic [31:0] dsz;
		case ($urandom_range(11))
			0: al = 7'd0;
			1: al = 7'd1;
			2: al = 7'd2;
			3: al = 7'd8;
			4: al = 7'd16;
			5: al = 7'd32;
			6: al = 7'd64;
			7: al = 7'($urandom_range(127));
			8: al = 7'd127;
			default: al = 7'd4;
		endcase
		write_reg(CFG_ALIGNMENT, 32'(al));
		write_reg(CFG_BIG_ENDIAN, 32'($urandom_range(1)));
		sect.delete();
		n_rec = $urandom_range(1, 3);
		for (int r = 0; r < n_rec; r++) begin
			if ($urandom_range(15) == 0) begin
				// oversized record, section ends inside it
				add_record($urandom, $urandom, $urandom, $urandom_range(24));
				break;
			end
			nsz = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1, 14));
			dsz = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
			add_record(nsz, dsz, $urandom, 1 << 20);
		end
		sz = sect.size();
		case ($urandom_range(11))
			0: sz = $urandom_range(sect.size() - 1);
			1: sz = sz + $urandom_range(1, 6);
			2: sz = 32'hFFFF_FFFF;
			3: sz = 32'd0;
			default: ;
		endcase
		write_reg(CFG_SECTION_SIZE, sz);
		cfg_release();
		extra = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
		play(extra, -1, 1'b1);
	endtask

	initial begin
		tags = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// section size is zero after reset
		sect.delete();
		sect = {sect, 8'hFF};
		play(0, -1, 1'b0);

		// one name byte and one descriptor byte, each padded to two,
		// then a cut-off header and a byte past the end; pause mid header
		write_reg(CFG_ALIGNMENT, 32'd2);
		write_reg(CFG_BIG_ENDIAN, 32'd1);
		sect.delete();
		add_record(32'd1, 32'd1, 32'hFFFF_FFFF, 1 << 20);
		sect = {sect, 8'h00};
		write_reg(CFG_SECTION_SIZE, sect.size());
		cfg_release();
		play(1, 6, 1'b0);

		while (bytes_sent < 1300) begin
			if (bytes_sent >= 866) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (bytes_sent >= 433) begin
				src_idle_pct = 68;
				snk_idle_pct = 29;
			end
			random_section();
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (tags.mismatches == 0 && tags.pending() == 0)
			$display("elf_note_record_deframer_unit verification clean");
		else
			$display("elf_note_record_deframer_unit verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("elf_note_record_deframer_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
